@@ rtl/core/fdt_subtree_skip_walker_defines.svh @@
// ---------------------------------------------------------------------------
// FDT subtree skip walker assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef FDT_SUBTREE_SKIP_WALKER_DEFINES_SVH
`define FDT_SUBTREE_SKIP_WALKER_DEFINES_SVH

`ifndef SYNTH
`define FDTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdtw: same-cycle check failed");
`define FDTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdtw: next-cycle check failed");
`else
`define FDTW_ASSERT_NOW(lbl, ante, cons)
`define FDTW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/fdtw_pkg.sv @@
// ---------------------------------------------------------------------------
// FDT walker package
// Tags, status codes, depth sizing and the result record of one step.
// ---------------------------------------------------------------------------
package fdtw_pkg;

  localparam int unsigned MAX_DEPTH = 255;
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);

  localparam logic [31:0] TAG_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TAG_END_NODE   = 32'd2;
  localparam logic [31:0] TAG_PROP       = 32'd3;
  localparam logic [31:0] TAG_NOP        = 32'd4;

  typedef enum logic [1:0] {
    ST_MORE    = 2'd0,
    ST_DONE    = 2'd1,
    ST_BAD     = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] end_offset;
  } result_t;

  // Word holds at least one zero byte.
  function automatic logic has_zero_byte(input logic [31:0] w);
    return ((w - 32'h0101_0101) & ~w & 32'h8080_8080) != 32'd0;
  endfunction

endpackage

@@ rtl/core/fdtw_core.sv @@
// ---------------------------------------------------------------------------
// FDT walker step engine
// Walk state registers and the per-word next-state and result logic.
// ---------------------------------------------------------------------------
module fdtw_core
  import fdtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step_en,
  input  logic [31:0] word,
  input  logic        first,
  input  logic [31:0] start_offset,
  input  logic [31:0] struct_limit,
  output result_t     res,
  output logic        busy
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_TAG        = 3'd1,
    PH_NAME       = 3'd2,
    PH_PLEN       = 3'd3,
    PH_NOFF_EMPTY = 3'd4,
    PH_NOFF_DATA  = 3'd5,
    PH_DATA       = 3'd6
  } phase_t;

  phase_t               phase, phase_next;
  logic [DEPTH_W-1:0]   nest_depth, nest_depth_next;
  logic [29:0]          data_words_left, data_words_left_next;
  logic [31:0]          cur_offset, cur_offset_next;
  logic                 props_only, props_only_next;

  always_comb begin
    phase_t             ph;
    logic [DEPTH_W-1:0] dep;
    logic [29:0]        dwl;
    logic [31:0]        off;
    logic [31:0]        off4;
    logic               po;
    logic               go_on;

    ph  = first ? PH_TAG : phase;
    dep = first ? '0 : nest_depth;
    dwl = first ? '0 : data_words_left;
    off = first ? start_offset : cur_offset;
    po  = first ? 1'b0 : props_only;
    off4 = off + 32'd4;

    phase_next           = ph;
    nest_depth_next      = dep;
    data_words_left_next = dwl;
    cur_offset_next      = off4;
    props_only_next      = po;
    res.status           = ST_MORE;
    res.end_offset       = '0;
    go_on                = 1'b0;

    unique case (ph)
      PH_TAG: begin
        if (po && word != TAG_PROP) begin
          // Property run ends here; leave this word unconsumed.
          cur_offset_next = off;
          phase_next      = PH_IDLE;
          res.status      = ST_DONE;
          res.end_offset  = off;
        end else if (word == TAG_BEGIN_NODE) begin
          if (dep >= DEPTH_W'(MAX_DEPTH)) begin
            cur_offset_next = off;
            phase_next      = PH_IDLE;
            res.status      = ST_BAD;
          end else begin
            nest_depth_next = dep + DEPTH_W'(1);
            phase_next      = PH_NAME;
          end
        end else if (word == TAG_END_NODE) begin
          if (dep == '0) begin
            cur_offset_next = off;
            phase_next      = PH_IDLE;
            res.status      = ST_BAD;
          end else begin
            nest_depth_next = dep - DEPTH_W'(1);
            go_on = (off4 < struct_limit) && (po || (dep - DEPTH_W'(1)) != '0);
            phase_next      = go_on ? PH_TAG : PH_IDLE;
            res.status      = go_on ? ST_MORE : ST_DONE;
            res.end_offset  = go_on ? '0 : off4;
          end
        end else if (word == TAG_PROP) begin
          if (dep == '0) props_only_next = 1'b1;
          phase_next = PH_PLEN;
        end else if (word == TAG_NOP) begin
          go_on = (off4 < struct_limit) && (po || dep != '0);
          phase_next     = go_on ? PH_TAG : PH_IDLE;
          res.status     = go_on ? ST_MORE : ST_DONE;
          res.end_offset = go_on ? '0 : off4;
        end else begin
          cur_offset_next = off;
          phase_next      = PH_IDLE;
          res.status      = ST_BAD;
        end
      end
      PH_NAME: begin
        if (has_zero_byte(word)) begin
          go_on = (off4 < struct_limit) && (po || dep != '0);
          phase_next     = go_on ? PH_TAG : PH_IDLE;
          res.status     = go_on ? ST_MORE : ST_DONE;
          res.end_offset = go_on ? '0 : off4;
        end
      end
      PH_PLEN: begin
        if (word == 32'd0) begin
          phase_next = PH_NOFF_EMPTY;
        end else begin
          // Round length up to words, minus the one counted on entry to data.
          data_words_left_next = word[31:2] - ((word[1:0] == 2'd0) ? 30'd1 : 30'd0);
          phase_next = PH_NOFF_DATA;
        end
      end
      PH_NOFF_EMPTY: begin
        go_on = (off4 < struct_limit) && (po || dep != '0);
        phase_next     = go_on ? PH_TAG : PH_IDLE;
        res.status     = go_on ? ST_MORE : ST_DONE;
        res.end_offset = go_on ? '0 : off4;
      end
      PH_NOFF_DATA: begin
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        if (dwl == '0) begin
          go_on = (off4 < struct_limit) && (po || dep != '0);
          phase_next     = go_on ? PH_TAG : PH_IDLE;
          res.status     = go_on ? ST_MORE : ST_DONE;
          res.end_offset = go_on ? '0 : off4;
        end else begin
          data_words_left_next = dwl - 30'd1;
        end
      end
      default: begin
        // No walk in progress: hold everything.
        cur_offset_next = off;
        res.status      = ST_IGNORED;
      end
    endcase
  end

  assign busy = (phase != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      nest_depth      <= '0;
      data_words_left <= '0;
      cur_offset      <= '0;
      props_only      <= 1'b0;
    end else if (step_en) begin
      phase           <= phase_next;
      nest_depth      <= nest_depth_next;
      data_words_left <= data_words_left_next;
      cur_offset      <= cur_offset_next;
      props_only      <= props_only_next;
    end
  end

endmodule

@@ rtl/core/fdt_subtree_skip_walker.sv @@
// ---------------------------------------------------------------------------
// FDT subtree skip walker
// Walks the devicetree structure block one word per item and reports the
// offset just past the node, NOP or property run at the start offset.
// ---------------------------------------------------------------------------
// Feed structure words in order, one item per word, with first set on the word
// at start_offset. Every item yields exactly one result: need more, finished
// (with end_offset), malformed, or ignored when no walk is open. The block
// takes one item per cycle while the result output is not stalled; a stalled
// result holds off new items once the input register is full. Each item passes
// through the input register, then its step result is captured in the result
// register and presented. The rate is set by the tag decode and offset/depth
// update in the step engine, which depends on the previous word's state. Write
// struct_limit only while the block is idle; the config port is always ready.
`include "fdt_subtree_skip_walker_defines.svh"

module fdt_subtree_skip_walker
  import fdtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // structure words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] word,
  input  logic        first,
  input  logic [31:0] start_offset,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] end_offset,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] struct_limit
);

  // Input register.
  logic        s1_valid;
  logic [31:0] s1_word;
  logic        s1_first;
  logic [31:0] s1_start;

  // Result register.
  result_t     out_res;

  logic [31:0] limit;
  logic        step_fire;
  result_t     step_res;
  logic        busy;

  // Advance a word into the engine whenever the result slot is free or draining.
  assign step_fire = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || step_fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_valid) begin
      limit <= struct_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Payload needs no reset; load only on accept.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word  <= word;
      s1_first <= first;
      s1_start <= start_offset;
    end
  end

  fdtw_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step_en      (step_fire),
    .word         (s1_word),
    .first        (s1_first),
    .start_offset (s1_start),
    .struct_limit (limit),
    .res          (step_res),
    .busy         (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_res <= step_res;
    end
  end

  assign status     = out_res.status;
  assign end_offset = out_res.end_offset;

  // A stalled result must block new words once the input register is full.
  `FDTW_ASSERT_NOW(a_hold_when_full, s1_valid && out_valid && !out_ready, !in_ready)
  // Only a finished walk carries an offset.
  `FDTW_ASSERT_NOW(a_offset_only_done,
                   out_valid && out_res.status != ST_DONE, out_res.end_offset == 32'd0)
  // A non-first word with no walk open comes back as ignored.
  `FDTW_ASSERT_NEXT(a_idle_ignored, step_fire && !s1_first && !busy,
                    out_valid && out_res.status == ST_IGNORED)

endmodule
